>>> hdl/frc_pkg.sv
// package for the fuzzy relation composition core: constants, payload types, states
`timescale 1ns / 1ps

package frc_pkg;

	// matrix geometry
	localparam int MAX_DIM    = 16;
	localparam int IDX_W      = 4;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int DIM_W      = 5;

	// grade format, unsigned Q1.15
	localparam int GRADE_W         = 16;
	localparam int GRADE_FRAC_BITS = 15;
	localparam int PROD_W          = 2 * GRADE_W;
	localparam logic [GRADE_W-1:0] GRADE_ONE  = GRADE_W'(1 << GRADE_FRAC_BITS);
	localparam logic [PROD_W:0]    GRADE_HALF = (PROD_W + 1)'(1 << (GRADE_FRAC_BITS - 1));

	// opcodes
	localparam logic [1:0] OP_WR_A  = 2'd0;
	localparam logic [1:0] OP_WR_B  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd3;

	// composition modes
	localparam logic MODE_MAX_MIN  = 1'b0;
	localparam logic MODE_MAX_PROD = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [IDX_W-1:0]   row_index;
		logic [IDX_W-1:0]   col_index;
		logic [GRADE_W-1:0] element_value;
	} req_t;

	typedef struct packed {
		logic [GRADE_W-1:0] composed_value;
		logic               out_of_range;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_FLUSH,
		S_EMIT
	} state_t;

endpackage

>>> hdl/fuzzy_relation_composition_core.sv
// fuzzy max-min / max-product relation composition core
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------
//  req      | in  | req_valid / req_stall   | frc_pkg::req_t
//  rsp      | out | rsp_valid / rsp_stall   | frc_pkg::rsp_t
//  cfg      | in  | cfg_we                  | cfg_index, cfg_data
//
// a write request keeps the core in IDLE; the next request is taken right after
// a query issues one memory read pair per cycle through the A and B stores for
// inner_len steps (capped at 16), then read, term and max stages drain before the
// result is loaded; an out-of-range query goes from IDLE straight to the result
// stores are not cleared on reset
// rsp_stall holds the result register; a new query waits only at its end
`timescale 1ns / 1ps

module fuzzy_relation_composition_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  frc_pkg::req_t                 req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output frc_pkg::rsp_t                 rsp_data,
	input  logic                          cfg_we,
	input  logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frc_pkg::DIM_W-1:0]     cfg_data
);

	// configuration registers
	logic                          mode_q;
	logic [frc_pkg::DIM_W-1:0]     rows_q;
	logic [frc_pkg::DIM_W-1:0]     inner_q;
	logic [frc_pkg::DIM_W-1:0]     cols_q;

	// control
	frc_pkg::state_t               state_q, state_d;
	logic [frc_pkg::DIM_W-1:0]     k_q;
	logic [frc_pkg::IDX_W-1:0]     row_q;
	logic [frc_pkg::IDX_W-1:0]     col_q;
	logic                          oor_q;
	logic [frc_pkg::GRADE_W-1:0]   best_q;

	// stores and pipeline
	logic [frc_pkg::GRADE_W-1:0]   mem_a [frc_pkg::STORE_DEPTH];
	logic [frc_pkg::GRADE_W-1:0]   mem_b [frc_pkg::STORE_DEPTH];
	logic [frc_pkg::GRADE_W-1:0]   rd_a_s1;
	logic [frc_pkg::GRADE_W-1:0]   rd_b_s1;
	logic                          rd_vld_s1;
	logic [frc_pkg::GRADE_W-1:0]   term_s2;
	logic                          term_vld_s2;

	// output register
	logic                          rsp_valid_q;
	frc_pkg::rsp_t                 rsp_q;

	// combinational control
	logic                          req_fire;
	logic                          wr_a;
	logic                          wr_b;
	logic                          start_query;
	logic                          query_oor;
	logic                          issue;
	logic                          emit;
	logic [frc_pkg::DIM_W-1:0]     rows_lim;
	logic [frc_pkg::DIM_W-1:0]     cols_lim;
	logic [frc_pkg::DIM_W-1:0]     inner_lim;
	logic [frc_pkg::GRADE_W-1:0]   wr_value;
	logic [frc_pkg::ADDR_W-1:0]    wr_addr;
	logic [frc_pkg::ADDR_W-1:0]    rd_addr_a;
	logic [frc_pkg::ADDR_W-1:0]    rd_addr_b;
	logic [frc_pkg::PROD_W-1:0]    prod;
	logic [frc_pkg::PROD_W:0]      prod_rnd;
	logic [frc_pkg::GRADE_W-1:0]   term_d;

	// dimension limits, oversized values act as the store size
	assign rows_lim  = (rows_q  > frc_pkg::DIM_W'(frc_pkg::MAX_DIM)) ?
		frc_pkg::DIM_W'(frc_pkg::MAX_DIM) : rows_q;
	assign cols_lim  = (cols_q  > frc_pkg::DIM_W'(frc_pkg::MAX_DIM)) ?
		frc_pkg::DIM_W'(frc_pkg::MAX_DIM) : cols_q;
	assign inner_lim = (inner_q > frc_pkg::DIM_W'(frc_pkg::MAX_DIM)) ?
		frc_pkg::DIM_W'(frc_pkg::MAX_DIM) : inner_q;

	// request decode
	assign req_fire    = req_valid && !req_stall;
	assign wr_a        = req_fire && (req_data.opcode == frc_pkg::OP_WR_A);
	assign wr_b        = req_fire && (req_data.opcode == frc_pkg::OP_WR_B);
	assign start_query = req_fire && (req_data.opcode == frc_pkg::OP_QUERY);
	assign query_oor   = ({1'b0, req_data.row_index} >= rows_lim) ||
		({1'b0, req_data.col_index} >= cols_lim);
	assign wr_value    = (req_data.element_value > frc_pkg::GRADE_ONE) ?
		frc_pkg::GRADE_ONE : req_data.element_value;
	assign wr_addr     = {req_data.row_index, req_data.col_index};
	assign rd_addr_a   = {row_q, k_q[frc_pkg::IDX_W-1:0]};
	assign rd_addr_b   = {k_q[frc_pkg::IDX_W-1:0], col_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		issue     = 1'b0;
		emit      = 1'b0;
		case (state_q)
			frc_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req_data.opcode == frc_pkg::OP_QUERY) begin
					state_d = query_oor ? frc_pkg::S_EMIT : frc_pkg::S_ISSUE;
				end
			end
			frc_pkg::S_ISSUE: begin
				if (k_q < inner_lim) begin
					issue = 1'b1;
				end else begin
					state_d = frc_pkg::S_FLUSH;
				end
			end
			frc_pkg::S_FLUSH: begin
				if (!rd_vld_s1 && !term_vld_s2) begin
					state_d = frc_pkg::S_EMIT;
				end
			end
			frc_pkg::S_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					emit    = 1'b1;
					state_d = frc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = frc_pkg::S_IDLE;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= frc_pkg::MODE_MAX_MIN;
			rows_q  <= frc_pkg::DIM_W'(frc_pkg::MAX_DIM);
			inner_q <= frc_pkg::DIM_W'(frc_pkg::MAX_DIM);
			cols_q  <= frc_pkg::DIM_W'(frc_pkg::MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				frc_pkg::CFG_MODE:      mode_q  <= cfg_data[0];
				frc_pkg::CFG_ROWS_A:    rows_q  <= cfg_data;
				frc_pkg::CFG_INNER_LEN: inner_q <= cfg_data;
				frc_pkg::CFG_COLS_B:    cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// store writes and registered reads
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= wr_value;
		end
		if (wr_b) begin
			mem_b[wr_addr] <= wr_value;
		end
		rd_a_s1 <= mem_a[rd_addr_a];
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	// term: min of the pair, or rounded product
	assign prod     = {{frc_pkg::GRADE_W{1'b0}}, rd_a_s1} * {{frc_pkg::GRADE_W{1'b0}}, rd_b_s1};
	assign prod_rnd = {1'b0, prod} + frc_pkg::GRADE_HALF;
	always_comb begin
		if (mode_q == frc_pkg::MODE_MAX_PROD) begin
			term_d = prod_rnd[frc_pkg::GRADE_FRAC_BITS +: frc_pkg::GRADE_W];
		end else begin
			term_d = (rd_a_s1 <= rd_b_s1) ? rd_a_s1 : rd_b_s1;
		end
	end

	always_ff @(posedge clk) begin
		term_s2 <= term_d;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			term_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1   <= issue;
			term_vld_s2 <= rd_vld_s1;
		end
	end

	// query context, inner counter and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			row_q  <= '0;
			col_q  <= '0;
			oor_q  <= 1'b0;
			best_q <= '0;
		end else begin
			if (start_query) begin
				k_q    <= '0;
				row_q  <= req_data.row_index;
				col_q  <= req_data.col_index;
				oor_q  <= query_oor;
				best_q <= '0;
			end else begin
				if (issue) begin
					k_q <= k_q + frc_pkg::DIM_W'(1);
				end
				if (term_vld_s2 && term_s2 > best_q) begin
					best_q <= term_s2;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.composed_value <= oor_q ? '0 : best_q;
			rsp_q.out_of_range   <= oor_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// read data only follows a cycle that issued a read
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == frc_pkg::S_ISSUE)
		else $error("read stage valid without issue");

	// term stage follows read stage
	assert property (@(posedge clk) disable iff (!arst_n)
		term_vld_s2 |-> $past(rd_vld_s1))
		else $error("term stage valid without read");

	// inner counter stays within the inner length while issuing
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == frc_pkg::S_ISSUE |-> k_q <= inner_lim)
		else $error("inner counter overrun");

	// an out-of-range result carries a zero grade
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.out_of_range |-> rsp_data.composed_value == '0)
		else $error("out-of-range result with nonzero grade");

	// a result is loaded only when the pipeline is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !rd_vld_s1 && !term_vld_s2)
		else $error("result loaded with terms in flight");

endmodule
